FILE: rtl/core/arot_pkg.sv
// Shared types and constants for the 3x3 axis rotation block.
`default_nettype none
package arot_pkg;

	localparam int ElemW  = 32;
	localparam int AngleW = 24;
	localparam int CoefW  = 32;
	localparam int TurnW  = 32;

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_PASS = 2'd3
	} axis_t;

	typedef struct packed {
		logic [1:0]               axis;
		logic [AngleW-1:0]        turn_angle;
		logic signed [ElemW-1:0]  in_r1c1;
		logic signed [ElemW-1:0]  in_r1c2;
		logic signed [ElemW-1:0]  in_r1c3;
		logic signed [ElemW-1:0]  in_r2c1;
		logic signed [ElemW-1:0]  in_r2c2;
		logic signed [ElemW-1:0]  in_r2c3;
		logic signed [ElemW-1:0]  in_r3c1;
		logic signed [ElemW-1:0]  in_r3c2;
		logic signed [ElemW-1:0]  in_r3c3;
	} in_item_t;

	typedef struct packed {
		logic signed [ElemW-1:0] out_r1c1;
		logic signed [ElemW-1:0] out_r1c2;
		logic signed [ElemW-1:0] out_r1c3;
		logic signed [ElemW-1:0] out_r2c1;
		logic signed [ElemW-1:0] out_r2c2;
		logic signed [ElemW-1:0] out_r2c3;
		logic signed [ElemW-1:0] out_r3c1;
		logic signed [ElemW-1:0] out_r3c2;
		logic signed [ElemW-1:0] out_r3c3;
	} out_item_t;

	// arctangent of 2^-i in 2^-32 turns
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t [32];
		t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
			32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
			32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443,
			32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
			32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20, 32'd10, 32'd5,
			32'd3, 32'd1, 32'd1, 32'd0};
		return t[i];
	endfunction

	localparam logic signed [CoefW-1:0] GainQ30 = 32'sd652032874;
	localparam logic signed [CoefW-1:0] OneQ30  = 32'sd1073741824;

endpackage
`default_nettype wire

FILE: rtl/core/axis_rotation_3x3_matrix.sv
// Top level: 3x3 matrix left-multiplied by an elementary axis rotation, or passed unchanged.
//  channel | valid      | stall      | payload
//  input   | in_valid   | in_stall   | in_data  (in_item_t)
//  output  | out_valid  | out_stall  | out_data (out_item_t)
// One matrix enters per cycle while no valid output is stalled; registered steps (stages capped at 32):
// angle load, CORDIC stages, clamp and quadrant register, lane multiply and round
// stages, and the output register.
// Reset clears only the valid bits of the pipeline and the output register.
// The whole pipeline advances together; out_stall on a valid output freezes it and raises in_stall.
`default_nettype none
module axis_rotation_3x3_matrix import arot_pkg::*; #(
	parameter int CORDIC_STAGES = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_item_t in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_item_t out_data
);
	localparam int N = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
	localparam int CL = N + 2;
	localparam int L = CL + 2;

	logic en;
	logic [L-1:0] vld_q;
	in_item_t dly_s [CL+1];
	logic signed [CoefW-1:0] c, s;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], in_valid};
			out_valid <= vld_q[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) dly_s[0] <= in_data;
	end
	for (genvar d = 0; d < CL; d++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) dly_s[d+1] <= dly_s[d];
		end
	end

	arot_cordic #(.ANGLE_BITS(AngleW), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .en(en), .angle(in_data.turn_angle), .cos_q(c), .sin_q(s)
	);

	in_item_t m;
	assign m = dly_s[CL-1];
	logic signed [ElemW-1:0] r1 [3], r2 [3], r3 [3];
	assign r1 = '{m.in_r1c1, m.in_r1c2, m.in_r1c3};
	assign r2 = '{m.in_r2c1, m.in_r2c2, m.in_r2c3};
	assign r3 = '{m.in_r3c1, m.in_r3c2, m.in_r3c3};

	// lane pair per column: row p' = a*k0 + b*k1, row q' = a*k2 + b*k3
	logic signed [ElemW-1:0] pa [3], pb [3], pr [3], qr [3];
	logic signed [CoefW-1:0] k0, k1, k2, k3;
	always_comb begin
		case (axis_t'(m.axis))
			AXIS_X: begin k0 = c; k1 = -s; k2 = s;  k3 = c; end
			AXIS_Y: begin k0 = c; k1 = s;  k2 = -s; k3 = c; end
			default: begin k0 = c; k1 = -s; k2 = s; k3 = c; end
		endcase
		for (int j = 0; j < 3; j++) begin
			case (axis_t'(m.axis))
				AXIS_X:  begin pa[j] = r2[j]; pb[j] = r3[j]; end
				AXIS_Y:  begin pa[j] = r1[j]; pb[j] = r3[j]; end
				default: begin pa[j] = r1[j]; pb[j] = r2[j]; end
			endcase
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_col
		arot_lane #(.ELEM_WIDTH(ElemW)) u_p (
			.clk(clk), .en(en), .a(pa[j]), .ka(k0), .b(pb[j]), .kb(k1), .res(pr[j]));
		arot_lane #(.ELEM_WIDTH(ElemW)) u_q (
			.clk(clk), .en(en), .a(pa[j]), .ka(k2), .b(pb[j]), .kb(k3), .res(qr[j]));
	end

	// f_s registers dly_s[CL] so the untouched rows line up with the lane results (lane inputs use dly_s[CL-1])
	in_item_t f_s;
	always_ff @(posedge clk) begin
		if (en) f_s <= dly_s[CL];
	end

	// merge: place mixed rows, pass the untouched row; AXIS_PASS passes all rows
	logic signed [ElemW-1:0] g1 [3], g2 [3], g3 [3];
	always_comb begin
		g1 = '{f_s.in_r1c1, f_s.in_r1c2, f_s.in_r1c3};
		g2 = '{f_s.in_r2c1, f_s.in_r2c2, f_s.in_r2c3};
		g3 = '{f_s.in_r3c1, f_s.in_r3c2, f_s.in_r3c3};
		case (axis_t'(f_s.axis))
			AXIS_X: begin g2 = pr; g3 = qr; end
			AXIS_Y: begin g1 = pr; g3 = qr; end
			AXIS_Z: begin g1 = pr; g2 = qr; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= '{g1[0], g1[1], g1[2], g2[0], g2[1], g2[2], g3[0], g3[1], g3[2]};
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall mismatch");
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[L-1] && f_s.axis == AXIS_PASS) |=> out_data.out_r1c1 == $past(f_s.in_r1c1))
		else $error("pass-through altered");
endmodule
`default_nettype wire

FILE: rtl/core/arot_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q1.30.
`default_nettype none
module arot_cordic import arot_pkg::*; #(
	parameter int ANGLE_BITS    = 24,
	parameter int CORDIC_STAGES = 24
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [ANGLE_BITS-1:0]   angle,
	output logic signed [CoefW-1:0]      cos_q,
	output logic signed [CoefW-1:0]      sin_q
);
	localparam int N = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
	localparam int XW = 34;

	logic signed [XW-1:0] x_s [N+1];
	logic signed [XW-1:0] y_s [N+1];
	logic signed [TurnW:0] z_s [N+1];
	logic [1:0] quad_s [N+1];
	logic [TurnW-1:0] turn;

	assign turn = TurnW'({angle, {(TurnW-ANGLE_BITS){1'b0}}});

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= XW'(GainQ30);
			y_s[0]    <= '0;
			z_s[0]    <= {3'b000, turn[TurnW-3:0]};
			quad_s[0] <= turn[TurnW-1:TurnW-2];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				quad_s[i+1] <= quad_s[i];
				if (!z_s[i][TurnW]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed({1'b0, atan_turn(i)});
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed({1'b0, atan_turn(i)});
				end
			end
		end
	end

	logic signed [XW-1:0] xc, yc;
	always_comb begin
		xc = x_s[N];
		yc = y_s[N];
		if (xc > XW'(OneQ30)) xc = XW'(OneQ30);
		if (xc < -XW'(OneQ30)) xc = -XW'(OneQ30);
		if (yc > XW'(OneQ30)) yc = XW'(OneQ30);
		if (yc < -XW'(OneQ30)) yc = -XW'(OneQ30);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s[N])
				2'd0: begin cos_q <= CoefW'(xc);  sin_q <= CoefW'(yc);  end
				2'd1: begin cos_q <= CoefW'(-yc); sin_q <= CoefW'(xc);  end
				2'd2: begin cos_q <= CoefW'(-xc); sin_q <= CoefW'(-yc); end
				default: begin cos_q <= CoefW'(yc); sin_q <= CoefW'(-xc); end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/arot_lane.sv
// One column lane: mixes two elements with two coefficients, rounds, saturates.
`default_nettype none
module arot_lane import arot_pkg::*; #(
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [ELEM_WIDTH-1:0]  a,
	input  wire logic signed [CoefW-1:0]       ka,
	input  wire logic signed [ELEM_WIDTH-1:0]  b,
	input  wire logic signed [CoefW-1:0]       kb,
	output logic signed [ELEM_WIDTH-1:0]       res
);
	localparam int PW = ELEM_WIDTH + CoefW;
	localparam int SW = PW + 1;

	logic signed [PW-1:0] pa_s1, pb_s1;
	logic signed [SW-1:0] sum;
	logic signed [SW-31:0] sh;
	logic signed [ELEM_WIDTH-1:0] maxv, minv;

	assign maxv = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
	assign minv = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= PW'(a) * PW'(ka);
			pb_s1 <= PW'(b) * PW'(kb);
		end
	end

	assign sum = SW'(pa_s1) + SW'(pb_s1) + SW'(64'sd536870912);
	assign sh  = sum[SW-1:30];

	always_ff @(posedge clk) begin
		if (en) begin
			if (sh > (SW-30)'(maxv))      res <= maxv;
			else if (sh < (SW-30)'(minv)) res <= minv;
			else                          res <= ELEM_WIDTH'(sh);
		end
	end
endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the 3x3 elementary axis rotation block.
`default_nettype none
module tb;
	import arot_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Latency = 24 + 5;
	localparam int CycleLimit = 400000;
	localparam int RandItems = 800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	in_item_t pending_q [$];
	out_item_t rotated_q [$];
	int mismatches = 0;
	int cycles = 0;
	int hold_cycles = 0;
	bit hold_req = 1'b0;
	bit all_queued = 1'b0;
	bit drain_req = 1'b0;
	bit drain_done = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	axis_rotation_3x3_matrix dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #2 clk = ~clk;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic void sin_cos(logic [23:0] ang, output longint c, output longint s);
		logic [31:0] t;
		longint x, y, z, dx, dy;
		int k;
		t = {ang, 8'd0};
		x = 652032874;
		y = 0;
		z = longint'(t[29:0]);
		for (k = 0; k < 24; k++) begin
			dx = floor_shift(y, k);
			dy = floor_shift(x, k);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_turn(k));
			end else begin
				x += dx; y -= dy; z += longint'(atan_turn(k));
			end
		end
		if (x > 1073741824) x = 1073741824;
		if (x < -1073741824) x = -1073741824;
		if (y > 1073741824) y = 1073741824;
		if (y < -1073741824) y = -1073741824;
		case (t[31:30])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic logic signed [31:0] blend(logic signed [31:0] a, longint ka,
			logic signed [31:0] b, longint kb);
		logic signed [127:0] acc;
		acc = 128'(signed'(a)) * 128'(ka) + 128'(signed'(b)) * 128'(kb) + (128'sd1 <<< 29);
		acc = acc >>> 30;
		if (acc > 128'sd2147483647) return 32'sh7fffffff;
		if (acc < -128'sd2147483648) return 32'sh80000000;
		return acc[31:0];
	endfunction

	function automatic out_item_t rotate_matrix(in_item_t m);
		out_item_t r;
		longint c, s;
		logic signed [31:0] a [9];
		logic signed [31:0] o [9];
		int k;
		a = '{m.in_r1c1, m.in_r1c2, m.in_r1c3, m.in_r2c1, m.in_r2c2, m.in_r2c3,
			m.in_r3c1, m.in_r3c2, m.in_r3c3};
		o = a;
		if (axis_t'(m.axis) != AXIS_PASS) begin
			sin_cos(m.turn_angle, c, s);
			for (k = 0; k < 3; k++) begin
				case (axis_t'(m.axis))
					AXIS_X: begin
						o[3+k] = blend(a[3+k], c, a[6+k], -s);
						o[6+k] = blend(a[3+k], s, a[6+k], c);
					end
					AXIS_Y: begin
						o[k] = blend(a[k], c, a[6+k], s);
						o[6+k] = blend(a[k], -s, a[6+k], c);
					end
					default: begin
						o[k] = blend(a[k], c, a[3+k], -s);
						o[3+k] = blend(a[k], s, a[3+k], c);
					end
				endcase
			end
		end
		r = {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8]};
		return r;
	endfunction

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'(signed'($urandom_range(0, 262144)) - 131072);
			3: return {{16{1'b0}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t rand_matrix();
		in_item_t m;
		m.axis = 2'($urandom);
		case ($urandom_range(0, 5))
			0: m.turn_angle = 24'($urandom_range(0, 3)) << 22;
			1: m.turn_angle = (24'($urandom_range(0, 3)) << 22) + 24'($urandom_range(0, 8)) - 24'd4;
			default: m.turn_angle = 24'($urandom);
		endcase
		m.in_r1c1 = rand_elem(); m.in_r1c2 = rand_elem(); m.in_r1c3 = rand_elem();
		m.in_r2c1 = rand_elem(); m.in_r2c2 = rand_elem(); m.in_r2c3 = rand_elem();
		m.in_r3c1 = rand_elem(); m.in_r3c2 = rand_elem(); m.in_r3c3 = rand_elem();
		return m;
	endfunction

	// directed: extremes of elements and angles for every axis
	initial begin
		in_item_t m;
		int ax, k;
		logic [23:0] angs [6];
		angs = '{24'h000000, 24'h400000, 24'h800000, 24'hc00000, 24'hffffff, 24'h200000};
		for (ax = 0; ax < 4; ax++)
			for (k = 0; k < 6; k++) begin
				m.axis = 2'(ax);
				m.turn_angle = angs[k];
				m.in_r1c1 = 32'h7fffffff; m.in_r1c2 = 32'h80000000; m.in_r1c3 = 32'h00010000;
				m.in_r2c1 = 32'h80000000; m.in_r2c2 = 32'h7fffffff; m.in_r2c3 = 32'hffff0000;
				m.in_r3c1 = (k[0]) ? 32'h7fffffff : 32'h80000000;
				m.in_r3c2 = 32'h7fffffff; m.in_r3c3 = 32'h00000000;
				if (ax * 6 + k < 25) pending_q.push_back(m);
			end
		for (k = 0; k < RandItems; k++)
			pending_q.push_back(rand_matrix());
		all_queued = 1'b1;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				rotated_q.push_back(rotate_matrix(in_data));
				void'(pending_q.pop_front());
			end
			if (in_valid && in_stall) begin
				// hold the stalled transaction
			end else if (drain_req && (rotated_q.size() > 0 || (in_valid && !in_stall))) begin
				in_valid <= 1'b0;
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_q[0];
				if ($urandom_range(0, 3) == 0)
					send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// pressure phases, keyed to how far the stimulus has gone
	always @(posedge clk) begin
		if (pending_q.size() == 500 && !hold_req) begin
			hold_req <= 1'b1;
			hold_cycles <= 120;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
		if (pending_q.size() == 300 && all_queued && !drain_done) begin
			drain_req <= 1'b1;
			drain_done <= 1'b1;
		end else if (drain_req && rotated_q.size() == 0 && !in_valid) begin
			drain_req <= 1'b0;
		end
	end

	// monitor and receiver
	always @(posedge clk) begin
		out_item_t want;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (rotated_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("unexpected transaction %h", out_data);
				end else begin
					want = rotated_q.pop_front();
					if (want !== out_data) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch exp %h got %h", want, out_data);
					end
				end
			end
			if (hold_cycles > 1) begin
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		wait (all_queued);
		wait (arst_n && pending_q.size() == 0 && rotated_q.size() == 0);
		repeat (Latency + 10) @(posedge clk);
		if (mismatches == 0 && rotated_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		wait (cycles >= CycleLimit);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/arot_pkg.sv
rtl/core/arot_cordic.sv
rtl/core/arot_lane.sv
rtl/core/axis_rotation_3x3_matrix.sv
tb/tb.sv
